>>> rtl/dssfw_pkg.sv
// Shared types and constants for the decimal seven-segment frame writer.
// Depends on nothing; imported by every module of the block.
package dssfw_pkg;

	// Number of decimal digits shown per number
	localparam int DIGIT_COUNT = 8;
	localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	// Depth of the digit queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Reciprocal of ten: floor(n * DIV10_MAGIC / 2^35) == n / 10 for 32-bit n
	localparam logic [31:0] DIV10_MAGIC = 32'hcccc_cccd;
	localparam int DIV10_SHIFT = 35;

	// Display controller bytes
	localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
	localparam logic [7:0] ADDR_BASE = 8'hc0;

	// Byte phase within one digit
	localparam logic [1:0] PH_CMD = 2'd0;
	localparam logic [1:0] PH_ADDR = 2'd1;
	localparam logic [1:0] PH_SEG = 2'd2;

	// One digit handed from front to back
	typedef struct packed {
		logic [3:0] digit;
		logic [POS_W-1:0] pos;
		logic last;
	} digit_entry_t;

	// Segment pattern of a decimal digit
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] code;
		unique case (d)
			4'd0: code = 8'h3f;
			4'd1: code = 8'h06;
			4'd2: code = 8'h5b;
			4'd3: code = 8'h4f;
			4'd4: code = 8'h66;
			4'd5: code = 8'h6d;
			4'd6: code = 8'h7d;
			4'd7: code = 8'h07;
			4'd8: code = 8'h7f;
			4'd9: code = 8'h6f;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/dssfw_front.sv
// Front end: accepts a number and peels off one decimal digit per cycle while the queue is not full.
// Depends on dssfw_pkg; feeds dssfw_queue.
module dssfw_front
	import dssfw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] in_value,
	output logic push,
	output digit_entry_t push_entry,
	input  logic queue_full
);

	logic busy_q;
	logic [31:0] val_q;
	logic [POS_W-1:0] cnt_q;
	logic [63:0] prod;
	logic [28:0] quot;
	logic [3:0] quot10_lo;
	logic last_digit;

	// Divide by ten through the reciprocal, remainder from the low bits
	assign prod = {32'd0, val_q} * {32'd0, DIV10_MAGIC};
	assign quot = prod[63:DIV10_SHIFT];
	assign quot10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
	assign last_digit = (cnt_q == POS_W'(DIGIT_COUNT - 1));

	assign in_ready = !busy_q;
	assign push = busy_q && !queue_full;
	assign push_entry.digit = val_q[3:0] - quot10_lo;
	assign push_entry.pos = POS_W'(DIGIT_COUNT - 1) - cnt_q;
	assign push_entry.last = last_digit;

	// Load a new number, then advance one digit per push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= cnt_q + POS_W'(1);
			if (last_digit) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Hold the remaining quotient
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			val_q <= in_value;
		end else if (push) begin
			val_q <= {3'b000, quot};
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ready)
		else $error("front accepts while digits remain");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_entry.digit <= 4'd9))
		else $error("digit out of range");

endmodule

>>> rtl/dssfw_queue.sv
// Short digit queue decoupling the front end from the byte emitter.
// Depends on dssfw_pkg.
module dssfw_queue
	import dssfw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  digit_entry_t push_entry,
	output logic full,
	input  logic pop,
	output logic empty,
	output digit_entry_t head
);

	digit_entry_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = slot_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

>>> rtl/dssfw_back.sv
// Back end: turns each queued digit into command, address and segment bytes.
// Depends on dssfw_pkg; drains dssfw_queue into the output register.
module dssfw_back
	import dssfw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  digit_entry_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_byte,
	output logic out_frame_end,
	output logic out_last
);

	logic [1:0] phase_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_frame_end_q;
	logic out_last_q;
	logic load;
	logic [7:0] next_byte;

	assign load = !empty && (!out_valid_q || out_ready);
	assign pop = load && (phase_q == PH_SEG);

	// Select the byte for the current phase
	always_comb begin
		unique case (phase_q)
			PH_CMD: next_byte = CMD_FIXED_ADDR;
			PH_ADDR: next_byte = ADDR_BASE + {(7 - POS_W)'(0), head.pos, 1'b0};
			default: next_byte = seg_code(head.digit);
		endcase
	end

	// Step through the three bytes of a digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= (phase_q == PH_SEG) ? PH_CMD : phase_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the output transaction until taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			out_frame_end_q <= (phase_q != PH_ADDR);
			out_last_q <= (phase_q == PH_SEG) && head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_frame_end = out_frame_end_q;
	assign out_last = out_last_q;

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("illegal byte phase");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |-> out_frame_end)
		else $error("last byte does not close a frame");

endmodule

>>> rtl/decimal_seven_segment_frame_writer.sv
// Decimal seven-segment frame writer: 3*DIGIT_COUNT bytes per number (24 at eight digits).
// A number's first digit is held in the front-end register, written into the queue, then loaded to m_tdata.
// Throughput: one byte per cycle while m_tready is high and a digit is queued; the byte emitter sets the pace,
// the digit splitter takes a new number only after pushing every digit and runs ahead through a four-entry queue.
// Reset: arst_n clears the queue, phase and valid flags at once; no clearing pass.
// Depends on dssfw_pkg, dssfw_front, dssfw_queue and dssfw_back.
module decimal_seven_segment_frame_writer
	import dssfw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata, // [31:0] number_value
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata, // [7:0] bus_byte
	output logic m_tuser, // [0] frame_end
	output logic m_tlast
);

	logic push;
	logic pop;
	logic full;
	logic empty;
	digit_entry_t push_entry;
	digit_entry_t head;

	// Split the number into digits
	dssfw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_value(s_tdata),
		.push(push),
		.push_entry(push_entry),
		.queue_full(full)
	);

	// Buffer digits between the two sides
	dssfw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(full),
		.pop(pop),
		.empty(empty),
		.head(head)
	);

	// Emit the byte stream
	dssfw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte(m_tdata),
		.out_frame_end(m_tuser),
		.out_last(m_tlast)
	);

endmodule
